// ===== hdl/pyuv_pkg.sv =====
package pyuv_pkg;

	localparam int BYTE_W = 8;
	localparam int COL_W  = 10;
	localparam int ROW_W  = 9;
	localparam int CFG_W  = 10;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] CFG_HALF_MODE    = 2'd2;

	localparam logic [COL_W-1:0] FRAME_WIDTH_RST  = 10'd640;
	localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 9'd480;

	typedef struct packed {
		logic       luma_we;
		logic       chroma_we;
		logic       rd_en;
		logic [1:0] lane;
	} mem_ctl_t;

endpackage

// ===== hdl/pyuv_in_if.sv =====
interface pyuv_in_if;
	logic                        valid;
	logic                        ready;
	logic [pyuv_pkg::BYTE_W-1:0] sample_byte;

	modport source (output valid, output sample_byte, input ready);
	modport sink (input valid, input sample_byte, output ready);
endinterface

// ===== hdl/pyuv_out_if.sv =====
interface pyuv_out_if;
	logic                        valid;
	logic                        ready;
	logic [pyuv_pkg::BYTE_W-1:0] luma;
	logic [pyuv_pkg::BYTE_W-1:0] chroma_first;
	logic [pyuv_pkg::BYTE_W-1:0] chroma_second;
	logic [pyuv_pkg::COL_W-1:0]  pixel_col;
	logic [pyuv_pkg::ROW_W-1:0]  pixel_row;
	logic                        frame_end;

	modport source (output valid, output luma, output chroma_first, output chroma_second,
		output pixel_col, output pixel_row, output frame_end, input ready);
	modport sink (input valid, input luma, input chroma_first, input chroma_second,
		input pixel_col, input pixel_row, input frame_end, output ready);
endinterface

// ===== hdl/planar_yuv420_to_packed_yuv_unit.sv =====
// A luma or first-chroma byte produces no pixel; a second-chroma byte gives its first pixel via
// the memory read register and then the output register. Luma and first-chroma bytes are
// taken one per cycle, as are second-chroma bytes in half mode unless the output stalls.
// In full mode a second-chroma byte yields four pixels in turn; the next waits for the last.
// Reset clears the plane, row and column counters and loads 640, 480 and full mode into the
// registers; the luma and chroma memories are not cleared and get no clearing pass.
module planar_yuv420_to_packed_yuv_unit #(
	parameter int MAX_WIDTH  = 640,
	parameter int MAX_HEIGHT = 480
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr,
	input  logic [pyuv_pkg::IDX_W-1:0]        cfg_index,
	input  logic [pyuv_pkg::CFG_W-1:0]        cfg_data,
	pyuv_in_if.sink                           sample,
	pyuv_out_if.source                        pixel
);

	localparam int DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
	localparam int AW    = $clog2(DEPTH);
	localparam int WLIM  = MAX_WIDTH & ~1;
	localparam int HLIM  = MAX_HEIGHT & ~1;

	typedef enum logic [2:0] {
		PL_LUMA = 3'b001,
		PL_CHR1 = 3'b010,
		PL_CHR2 = 3'b100
	} plane_t;

	plane_t                           plane_q;
	logic [pyuv_pkg::COL_W-1:0]       col_q;
	logic [pyuv_pkg::ROW_W-1:0]       row_q;
	logic [AW-1:0]                    base_q;
	logic [pyuv_pkg::COL_W-1:0]       fw_q;
	logic [pyuv_pkg::ROW_W-1:0]       fh_q;
	logic                             half_q;

	logic [pyuv_pkg::COL_W-1:0]       w_eff;
	logic [pyuv_pkg::ROW_W-1:0]       h_eff;
	logic [pyuv_pkg::COL_W-2:0]       cw;
	logic [pyuv_pkg::ROW_W-2:0]       chh;
	logic [pyuv_pkg::COL_W-1:0]       pw;
	logic [pyuv_pkg::ROW_W-1:0]       ph;
	logic                             col_end;
	logic                             row_end;
	logic                             in_acc;
	logic                             cfg_hit;
	logic [AW-1:0]                    addr;
	pyuv_pkg::mem_ctl_t               ctl;

	logic [3:0][pyuv_pkg::BYTE_W-1:0] luma_word;
	logic [pyuv_pkg::BYTE_W-1:0]      chroma_byte;

	logic                             valid_s1;
	logic [pyuv_pkg::BYTE_W-1:0]      sec_s1;
	logic [pyuv_pkg::COL_W-2:0]       ccol_s1;
	logic [pyuv_pkg::ROW_W-2:0]       crow_s1;
	logic                             last_s1;
	logic [1:0]                       sub_q;

	logic                             out_load;
	logic                             emit;
	logic                             last_sub;
	logic                             s1_free;
	logic [pyuv_pkg::BYTE_W+1:0]      luma_sum;

	logic                             out_valid_q;
	logic [pyuv_pkg::BYTE_W-1:0]      luma_q;
	logic [pyuv_pkg::BYTE_W-1:0]      cb_q;
	logic [pyuv_pkg::BYTE_W-1:0]      cr_q;
	logic [pyuv_pkg::COL_W-1:0]       pcol_q;
	logic [pyuv_pkg::ROW_W-1:0]       prow_q;
	logic                             fend_q;

	always_comb begin
		w_eff = {fw_q[pyuv_pkg::COL_W-1:1], 1'b0};
		if (w_eff < 10'd2) begin
			w_eff = 10'd2;
		end else if (32'(w_eff) > WLIM) begin
			w_eff = 10'(WLIM);
		end
		h_eff = {fh_q[pyuv_pkg::ROW_W-1:1], 1'b0};
		if (h_eff < 9'd2) begin
			h_eff = 9'd2;
		end else if (32'(h_eff) > HLIM) begin
			h_eff = 9'(HLIM);
		end
	end

	assign cw      = w_eff[pyuv_pkg::COL_W-1:1];
	assign chh     = h_eff[pyuv_pkg::ROW_W-1:1];
	assign pw      = (plane_q == PL_LUMA) ? w_eff : {1'b0, cw};
	assign ph      = (plane_q == PL_LUMA) ? h_eff : {1'b0, chh};
	assign col_end = (col_q == pw - 10'd1);
	assign row_end = (row_q == ph - 9'd1);
	assign in_acc  = sample.valid && sample.ready;
	assign cfg_hit = cfg_wr && (cfg_index == pyuv_pkg::CFG_FRAME_WIDTH ||
		cfg_index == pyuv_pkg::CFG_FRAME_HEIGHT || cfg_index == pyuv_pkg::CFG_HALF_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q   <= pyuv_pkg::FRAME_WIDTH_RST;
			fh_q   <= pyuv_pkg::FRAME_HEIGHT_RST;
			half_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				pyuv_pkg::CFG_FRAME_WIDTH:  fw_q   <= cfg_data;
				pyuv_pkg::CFG_FRAME_HEIGHT: fh_q   <= cfg_data[pyuv_pkg::ROW_W-1:0];
				pyuv_pkg::CFG_HALF_MODE:    half_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The block address advances by one chroma row after each odd luma row and after
	// every chroma row, so luma pairs of rows share their 2x2 block words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= PL_LUMA;
			col_q   <= '0;
			row_q   <= '0;
			base_q  <= '0;
		end else if (cfg_hit) begin
			plane_q <= PL_LUMA;
			col_q   <= '0;
			row_q   <= '0;
			base_q  <= '0;
		end else if (in_acc) begin
			if (col_end) begin
				col_q <= '0;
				if (row_end) begin
					row_q  <= '0;
					base_q <= '0;
					unique case (plane_q)
						PL_LUMA: plane_q <= PL_CHR1;
						PL_CHR1: plane_q <= PL_CHR2;
						PL_CHR2: plane_q <= PL_LUMA;
						default: plane_q <= PL_LUMA;
					endcase
				end else begin
					row_q <= row_q + 9'd1;
					if (plane_q != PL_LUMA || row_q[0]) begin
						base_q <= base_q + AW'(cw);
					end
				end
			end else begin
				col_q <= col_q + 10'd1;
			end
		end
	end

	assign addr = base_q + ((plane_q == PL_LUMA) ? AW'(col_q[pyuv_pkg::COL_W-1:1]) : AW'(col_q));

	assign ctl.luma_we   = in_acc && (plane_q == PL_LUMA);
	assign ctl.chroma_we = in_acc && (plane_q == PL_CHR1);
	assign ctl.rd_en     = in_acc && (plane_q == PL_CHR2);
	assign ctl.lane      = {row_q[0], col_q[0]};

	pyuv_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk         (clk),
		.ctl         (ctl),
		.addr        (addr),
		.wdata       (sample.sample_byte),
		.luma_word   (luma_word),
		.chroma_byte (chroma_byte)
	);

	assign out_load = !out_valid_q || pixel.ready;
	assign emit     = valid_s1 && out_load;
	assign last_sub = half_q || (sub_q == 2'd3);
	assign s1_free  = emit && last_sub;

	assign sample.ready = (plane_q != PL_CHR2) || !valid_s1 || s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sub_q    <= '0;
		end else begin
			if (ctl.rd_en) begin
				valid_s1 <= 1'b1;
			end else if (s1_free) begin
				valid_s1 <= 1'b0;
			end
			if (emit) begin
				sub_q <= last_sub ? 2'd0 : sub_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			sec_s1  <= sample.sample_byte;
			ccol_s1 <= col_q[pyuv_pkg::COL_W-2:0];
			crow_s1 <= row_q[pyuv_pkg::ROW_W-2:0];
			last_s1 <= col_end && row_end;
		end
	end

	assign luma_sum = 10'(luma_word[0]) + 10'(luma_word[1]) + 10'(luma_word[2])
		+ 10'(luma_word[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cb_q   <= chroma_byte;
			cr_q   <= sec_s1;
			fend_q <= last_s1 && last_sub;
			if (half_q) begin
				luma_q <= luma_sum[pyuv_pkg::BYTE_W+1:2];
				pcol_q <= {1'b0, ccol_s1};
				prow_q <= {1'b0, crow_s1};
			end else begin
				luma_q <= luma_word[sub_q];
				pcol_q <= {ccol_s1, sub_q[0]};
				prow_q <= {crow_s1, sub_q[1]};
			end
		end
	end

	assign pixel.valid         = out_valid_q;
	assign pixel.luma          = luma_q;
	assign pixel.chroma_first  = cb_q;
	assign pixel.chroma_second = cr_q;
	assign pixel.pixel_col     = pcol_q;
	assign pixel.pixel_row     = prow_q;
	assign pixel.frame_end     = fend_q;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_en |-> (!valid_s1 || s1_free))
		else $error("second-chroma transaction accepted while the block stage is busy");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_free) |=> (valid_s1 && $stable(sec_s1) && $stable(last_s1)))
		else $error("pending block changed before all its pixels left");

	a_sub_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(sub_q != 2'd0) |-> (valid_s1 && !half_q))
		else $error("pixel counter away from zero without a full-mode block");

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.luma_we, ctl.chroma_we, ctl.rd_en}))
		else $error("more than one memory access in a cycle");

endmodule

// ===== hdl/pyuv_store.sv =====
module pyuv_store #(
	parameter int DEPTH = 76800,
	parameter int AW    = 17
) (
	input  logic                                  clk,
	input  pyuv_pkg::mem_ctl_t                    ctl,
	input  logic [AW-1:0]                         addr,
	input  logic [pyuv_pkg::BYTE_W-1:0]           wdata,
	output logic [3:0][pyuv_pkg::BYTE_W-1:0]      luma_word,
	output logic [pyuv_pkg::BYTE_W-1:0]           chroma_byte
);

	// Each luma word holds one 2x2 block, lane {row parity, column parity}.
	logic [3:0][pyuv_pkg::BYTE_W-1:0] luma_mem [DEPTH];
	logic [pyuv_pkg::BYTE_W-1:0]      chroma_mem [DEPTH];
	logic [3:0][pyuv_pkg::BYTE_W-1:0] luma_word_q;
	logic [pyuv_pkg::BYTE_W-1:0]      chroma_byte_q;

	always_ff @(posedge clk) begin
		if (ctl.luma_we) begin
			luma_mem[addr][ctl.lane] <= wdata;
		end
		if (ctl.chroma_we) begin
			chroma_mem[addr] <= wdata;
		end
		if (ctl.rd_en) begin
			luma_word_q   <= luma_mem[addr];
			chroma_byte_q <= chroma_mem[addr];
		end
	end

	assign luma_word   = luma_word_q;
	assign chroma_byte = chroma_byte_q;

endmodule

// ===== bench/packed_pixel_check.sv =====
module packed_pixel_check #(
	parameter int MAX_WIDTH  = 640,
	parameter int MAX_HEIGHT = 480
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr,
	input  logic [pyuv_pkg::IDX_W-1:0] cfg_index,
	input  logic [pyuv_pkg::CFG_W-1:0] cfg_data,
	pyuv_in_if                         sample,
	pyuv_out_if                        pixel,
	output int                         mismatches,
	output int                         pixels_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import pyuv_pkg::*;

	typedef enum logic [1:0] {
		PLANE_LUMA,
		PLANE_CHROMA_FIRST,
		PLANE_CHROMA_SECOND
	} plane_e;

	typedef struct packed {
		logic [BYTE_W-1:0] luma;
		logic [BYTE_W-1:0] chroma_first;
		logic [BYTE_W-1:0] chroma_second;
		logic [COL_W-1:0]  pixel_col;
		logic [ROW_W-1:0]  pixel_row;
		logic              frame_end;
	} pixel_t;

	logic [BYTE_W-1:0] luma_mem [MAX_WIDTH*MAX_HEIGHT];
	logic [BYTE_W-1:0] chroma_mem [(MAX_WIDTH/2)*(MAX_HEIGHT/2)];
	pixel_t            expected_pixels [$];
	plane_e            plane;
	int unsigned       col_pos;
	int unsigned       row_pos;
	logic [COL_W-1:0]  width_reg;
	logic [ROW_W-1:0]  height_reg;
	logic              half_reg;
	logic              restart_frame;
	pixel_t            want_pixel;

	function automatic int unsigned clamp_dim(int unsigned code, int unsigned limit);
		int unsigned dim;
		dim = code & ~32'd1;
		if (dim < 2) dim = 2;
		if (dim > (limit & ~32'd1)) dim = limit & ~32'd1;
		return dim;
	endfunction

	function automatic pixel_t make_pixel(int unsigned y, int unsigned u, int unsigned v,
		int unsigned col, int unsigned row, logic last);
		pixel_t px;
		px.luma          = BYTE_W'(y);
		px.chroma_first  = BYTE_W'(u);
		px.chroma_second = BYTE_W'(v);
		px.pixel_col     = COL_W'(col);
		px.pixel_row     = ROW_W'(row);
		px.frame_end     = last;
		return px;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0h, expected %0h (pixel at column %0d row %0d)",
				name, got, want, want_pixel.pixel_col, want_pixel.pixel_row));
		end
	endtask

	task automatic convert_sample(input logic [BYTE_W-1:0] value);
		int unsigned w, h, cw, ch, span, depth, x0, y0, u, a, b, c, d;
		logic last;
		w     = clamp_dim(width_reg, MAX_WIDTH);
		h     = clamp_dim(height_reg, MAX_HEIGHT);
		cw    = w / 2;
		ch    = h / 2;
		span  = (plane == PLANE_LUMA) ? w : cw;
		depth = (plane == PLANE_LUMA) ? h : ch;
		case (plane)
			PLANE_LUMA: luma_mem[row_pos * w + col_pos] = value;
			PLANE_CHROMA_FIRST: chroma_mem[row_pos * cw + col_pos] = value;
			default: begin
				u    = chroma_mem[row_pos * cw + col_pos];
				x0   = 2 * col_pos;
				y0   = 2 * row_pos;
				a    = luma_mem[y0 * w + x0];
				b    = luma_mem[y0 * w + x0 + 1];
				c    = luma_mem[(y0 + 1) * w + x0];
				d    = luma_mem[(y0 + 1) * w + x0 + 1];
				last = (col_pos == cw - 1) && (row_pos == ch - 1);
				if (half_reg) begin
					expected_pixels.push_back(make_pixel((a + b + c + d) >> 2, u, value,
						col_pos, row_pos, last));
				end else begin
					expected_pixels.push_back(make_pixel(a, u, value, x0, y0, 1'b0));
					expected_pixels.push_back(make_pixel(b, u, value, x0 + 1, y0, 1'b0));
					expected_pixels.push_back(make_pixel(c, u, value, x0, y0 + 1, 1'b0));
					expected_pixels.push_back(make_pixel(d, u, value, x0 + 1, y0 + 1, last));
				end
			end
		endcase
		col_pos++;
		if (col_pos >= span) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= depth) begin
				row_pos = 0;
				case (plane)
					PLANE_LUMA: plane = PLANE_CHROMA_FIRST;
					PLANE_CHROMA_FIRST: plane = PLANE_CHROMA_SECOND;
					default: plane = PLANE_LUMA;
				endcase
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			plane      = PLANE_LUMA;
			col_pos    = 0;
			row_pos    = 0;
			width_reg  = FRAME_WIDTH_RST;
			height_reg = FRAME_HEIGHT_RST;
			half_reg   = 1'b0;
			mismatches = 0;
			expected_pixels.delete();
		end else begin
			if (cfg_wr) begin
				restart_frame = 1'b1;
				case (cfg_index)
					CFG_FRAME_WIDTH: width_reg = cfg_data[COL_W-1:0];
					CFG_FRAME_HEIGHT: height_reg = cfg_data[ROW_W-1:0];
					CFG_HALF_MODE: half_reg = cfg_data[0];
					default: restart_frame = 1'b0;
				endcase
				if (restart_frame) begin
					plane   = PLANE_LUMA;
					col_pos = 0;
					row_pos = 0;
				end
			end
			if (sample.valid && sample.ready) convert_sample(sample.sample_byte);
			if (pixel.valid && pixel.ready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("pixel at column %0d row %0d with none expected",
						pixel.pixel_col, pixel.pixel_row));
				end else begin
					want_pixel = expected_pixels.pop_front();
					compare_field("luma", pixel.luma, want_pixel.luma);
					compare_field("chroma_first", pixel.chroma_first, want_pixel.chroma_first);
					compare_field("chroma_second", pixel.chroma_second, want_pixel.chroma_second);
					compare_field("pixel_col", pixel.pixel_col, want_pixel.pixel_col);
					compare_field("pixel_row", pixel.pixel_row, want_pixel.pixel_row);
					compare_field("frame_end", pixel.frame_end, want_pixel.frame_end);
				end
			end
		end
		pixels_pending = expected_pixels.size();
	end

endmodule

// ===== bench/planar_yuv420_to_packed_yuv_unit_tb.sv =====
module planar_yuv420_to_packed_yuv_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pyuv_pkg::*;

	localparam int               MAX_W         = 640;
	localparam int               MAX_H         = 480;
	localparam logic [IDX_W-1:0] CFG_UNUSED    = 2'd3;
	localparam int               RANDOM_ITEMS  = 270;
	localparam int               SETTLE_CYCLES = 4;
	localparam int               FINAL_CYCLES  = 10;
	localparam int               CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned      WHOLE_FRAME   = 32'hFFFF_FFFF;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr;
	logic [IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	int                mismatches;
	int                pixels_pending;
	int                cycle_count = 0;
	int                stall_left  = 0;
	int                stall_pct   = 0;
	int                burst_left  = 0;
	int unsigned       sent_items  = 0;
	logic [BYTE_W-1:0] frame_a [6] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00};
	logic [BYTE_W-1:0] frame_b [6] = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h00, 8'hFF};
	logic [BYTE_W-1:0] frame_c [6] = '{8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'h80, 8'h01};

	pyuv_in_if  sample_ch();
	pyuv_out_if pixel_ch();

	planar_yuv420_to_packed_yuv_unit #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr(cfg_wr),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(sample_ch),
		.pixel(pixel_ch)
	);

	packed_pixel_check #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) pixel_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr(cfg_wr),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(sample_ch),
		.pixel(pixel_ch),
		.mismatches(mismatches),
		.pixels_pending(pixels_pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (cycle_count % 500 == 0) stall_pct <= 25 * $urandom_range(0, 3);
		if (stall_left != 0) begin
			pixel_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			pixel_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			pixel_ch.ready <= 1'b1;
		end
	end

	function automatic logic [CFG_W-1:0] dim_code(int unsigned dim, int unsigned limit,
		int unsigned code_max);
		if (dim == 2) return CFG_W'($urandom_range(0, 3));
		if (dim == limit) return CFG_W'($urandom_range(limit, code_max));
		return CFG_W'(dim | $urandom_range(0, 1));
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return BYTE_W'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wr    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_random_mode();
		write_reg(CFG_HALF_MODE, CFG_W'({$urandom, 1'($urandom_range(0, 1))}));
	endtask

	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pixels_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] value);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				sample_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sample_ch.valid       <= 1'b1;
		sample_ch.sample_byte <= value;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
	endtask

	task automatic send_frame(input int unsigned w, input int unsigned h, input int unsigned cut);
		int unsigned total, pause_at;
		total    = w * h + (w * h) / 2;
		pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, total - 1) : total;
		for (int unsigned i = 0; i < total && i < cut; i++) begin
			if (i == pause_at) begin
				wait_drained();
				if ($urandom_range(0, 1) == 0) write_reg(CFG_UNUSED, CFG_W'($urandom));
			end
			send_byte(pick_byte());
			sent_items++;
		end
	endtask

	initial begin
		int unsigned cur_w, cur_h;
		logic        need_restart;
		arst_n                = 1'b0;
		cfg_wr                = 1'b0;
		cfg_index             = CFG_FRAME_WIDTH;
		cfg_data              = '0;
		sample_ch.valid       = 1'b0;
		sample_ch.sample_byte = '0;
		pixel_ch.ready        = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Odd and undersized geometry codes both give a 2x2 frame; half mode is still at reset.
		write_reg(CFG_FRAME_WIDTH, 10'd3);
		write_reg(CFG_FRAME_HEIGHT, 10'd0);
		foreach (frame_a[i]) send_byte(frame_a[i]);
		// The next frame follows without a restart, with an ignored register write inside it.
		for (int i = 0; i < 6; i++) begin
			if (i == 3) begin
				wait_drained();
				write_reg(CFG_UNUSED, 10'h3FF);
			end
			send_byte(frame_b[i]);
		end
		wait_drained();
		write_reg(CFG_HALF_MODE, 10'h3FF);
		send_byte(8'h07);
		send_byte(8'h09);
		wait_drained();
		write_reg(CFG_HALF_MODE, 10'h001);
		foreach (frame_c[i]) send_byte(frame_c[i]);

		cur_w        = 2;
		cur_h        = 2;
		need_restart = 1'b0;
		while (sent_items < RANDOM_ITEMS) begin
			wait_drained();
			if (need_restart || $urandom_range(0, 2) != 0) begin
				cur_w = 2 * $urandom_range(1, 8);
				write_reg(CFG_FRAME_WIDTH, dim_code(cur_w, MAX_W, 1023));
			end
			if ($urandom_range(0, 2) != 0) begin
				cur_h = 2 * $urandom_range(1, 5);
				write_reg(CFG_FRAME_HEIGHT, dim_code(cur_h, MAX_H, 511));
			end
			if ($urandom_range(0, 1) != 0) write_random_mode();
			need_restart = 1'b0;
			repeat ($urandom_range(1, 3)) begin
				if (!need_restart) begin
					if ($urandom_range(0, 7) == 0) begin
						send_frame(cur_w, cur_h, $urandom_range(1, cur_w * cur_h * 3 / 2 - 1));
						need_restart = 1'b1;
					end else begin
						send_frame(cur_w, cur_h, WHOLE_FRAME);
					end
				end
			end
		end

		wait_drained();
		repeat (FINAL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pixels_pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/pyuv_pkg.sv
hdl/pyuv_in_if.sv
hdl/pyuv_out_if.sv
hdl/pyuv_store.sv
hdl/planar_yuv420_to_packed_yuv_unit.sv
bench/packed_pixel_check.sv
bench/planar_yuv420_to_packed_yuv_unit_tb.sv
